// ===== hw/rtl/afu_pkg.sv =====
// Shared types and codes for the activation function unit.
// No dependencies; used by afu_exp_step, afu_div_step, the top level and the testbench.
`default_nettype none

package afu_pkg;

  localparam logic [2:0] MODE_STEP  = 3'd0;
  localparam logic [2:0] MODE_RELU  = 3'd1;
  localparam logic [2:0] MODE_SQP   = 3'd2;
  localparam logic [2:0] MODE_GAUSS = 3'd3;
  localparam logic [2:0] MODE_TANH  = 3'd4;
  localparam logic [2:0] MODE_SWISH = 3'd5;

  localparam int unsigned EXP_STEPS = 22;  // bits of the Q16 exponent argument
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned DIV_STEPS = 17;  // quotient bits

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] a;
    logic [15:0]        m;     // |a|
    logic [21:0]        u;     // exponent argument, Q16
    logic [32:0]        e;     // exp(-u), Q32
    logic [30:0]        s;     // a*a + 2 in Q16
    logic [31:0]        sv;    // root remainder
    logic [31:0]        sr;    // root
    logic [50:0]        num;
    logic [33:0]        den;
    logic [16:0]        q;
    logic signed [17:0] spn;
    logic signed [18:0] spd;
    logic [15:0]        ysp;
    logic               sat;
    logic [8:0]         yg;
  } pipe_t;

endpackage

`default_nettype wire

// ===== hw/rtl/afu_exp_step.sv =====
// One exponent bit: multiply by exp(-2^(Idx-16)) when set, plus one root digit when Idx < SQRT_STEPS.
// Depends on afu_pkg.
`default_nettype none

module afu_exp_step #(
  parameter int unsigned Idx = 0
) (
  input  afu_pkg::pipe_t p_i,
  output afu_pkg::pipe_t p_o
);
  import afu_pkg::*;

  localparam logic [31:0] Coef =
    32'(longint'($exp(-(2.0 ** (real'(Idx) - 16.0))) * 4294967296.0));
  localparam bit SqOn = (Idx < SQRT_STEPS);
  localparam int unsigned SqShift = SqOn ? 30 - 2 * Idx : 0;
  localparam logic [31:0] SqBit = 32'(1) << SqShift;

  logic [64:0] prod;
  logic [31:0] trial;

  always_comb begin
    p_o   = p_i;
    prod  = 65'(p_i.e) * 65'(Coef);
    trial = p_i.sr + SqBit;
    if (p_i.u[Idx]) begin
      p_o.e = prod[64:32];
    end
    if (SqOn) begin
      if (p_i.sv >= trial) begin
        p_o.sv = p_i.sv - trial;
        p_o.sr = (p_i.sr >> 1) + SqBit;
      end else begin
        p_o.sr = p_i.sr >> 1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/afu_div_step.sv =====
// One restoring division step, quotient bit Sh.
// Depends on afu_pkg.
`default_nettype none

module afu_div_step #(
  parameter int unsigned Sh = 0
) (
  input  afu_pkg::pipe_t p_i,
  output afu_pkg::pipe_t p_o
);
  import afu_pkg::*;

  logic [50:0] dsh;

  always_comb begin
    p_o = p_i;
    dsh = 51'(p_i.den) << Sh;
    if (p_i.num >= dsh) begin
      p_o.num   = p_i.num - dsh;
      p_o.q[Sh] = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/activation_function_unit.sv =====
// Activation function unit top level: step, relu, squareplus, gauss, tanh, swish.
// Depends on afu_pkg, afu_exp_step, afu_div_step.
//
//   channel  | valid   | stall   | payload
//   request  | valid_i | stall_o | mode_i, x_i
//   result   | valid_o | stall_i | y_o, saturated_o
//
// One request per cycle while the result is not stalled; a request passes through
// 43 registers (input, 22 exponent/root stages, two post stages,
// 17 divider stages, output register) before valid_o rises.
// Per stage: one exponent bit (plus a root digit while Idx < SQRT_STEPS) or one quotient bit.
// Reset clears the valid bits only.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module activation_function_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic signed [15:0] x_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic signed [15:0] y_o,
  output logic             saturated_o
);
  import afu_pkg::*;

  localparam int unsigned P1  = EXP_STEPS + 1;
  localparam int unsigned P2  = P1 + 1;
  localparam int unsigned NST = P2 + DIV_STEPS + 1;

  pipe_t p_q [NST];
  pipe_t p_d [NST];
  logic [NST-1:0] vld_q;
  logic en;
  logic signed [15:0] y_q, y_d;
  logic sat_q, sat_d, vo_q;

  assign en      = !(vo_q && stall_i);
  assign stall_o = !en;
  assign valid_o = vo_q;
  assign y_o     = y_q;
  assign saturated_o = sat_q;

  // input stage
  logic [31:0] sq;
  logic [24:0] ut;
  logic        uz;
  always_comb begin
    p_d[0]      = '0;
    p_d[0].mode = mode_i;
    p_d[0].a    = x_i;
    p_d[0].m    = x_i[15] ? 16'(-x_i) : 16'(x_i);
    sq          = 32'($signed(x_i) * $signed(x_i));
    p_d[0].s    = 31'(sq + 32'd131072);
    p_d[0].sv   = sq + 32'd131072;
    case (mode_i)
      MODE_GAUSS: begin
        ut = sq[24:0];
        uz = |sq[31:22];
      end
      MODE_TANH:  begin
        ut = 25'(p_d[0].m) << 9;
        uz = |ut[24:22];
      end
      MODE_SWISH: begin
        ut = 25'(p_d[0].m) << 7;
        uz = |ut[24:22];
      end
      default: begin
        ut = '0;
        uz = 1'b0;
      end
    endcase
    p_d[0].u = uz ? 22'd0 : ut[21:0];
    p_d[0].e = uz ? 33'd0 : ONE_Q32;
  end

  for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
    afu_exp_step #(.Idx(j)) u_exp (.p_i(p_q[j]), .p_o(p_d[j+1]));
  end

  // post stage 1: divider operands, gauss rounding, squareplus candidate
  logic signed [17:0] sum1;
  logic [33:0] yg_sum;
  always_comb begin
    p_d[P1]     = p_q[P1-1];
    p_d[P1].den = 34'(ONE_Q32) + 34'(p_q[P1-1].e);
    p_d[P1].q   = '0;
    case (p_q[P1-1].mode)
      MODE_TANH:  p_d[P1].num = 51'(ONE_Q32 - p_q[P1-1].e) << 9;
      MODE_SWISH: begin
        if (p_q[P1-1].a[15]) begin
          p_d[P1].num = 51'(49'(p_q[P1-1].m) * 49'(p_q[P1-1].e)) << 1;
        end else begin
          p_d[P1].num = 51'(p_q[P1-1].m) << 33;
        end
      end
      default: p_d[P1].num = '0;
    endcase
    sum1 = 18'(p_q[P1-1].a) + 18'sd1 + $signed({2'b00, p_q[P1-1].sr[15:0]});
    p_d[P1].spn = sum1 >>> 1;
    p_d[P1].spd = 19'(p_d[P1].spn) * 19'sd2 + 19'sd2 - 19'(p_q[P1-1].a) - 19'sd1;
    yg_sum      = 34'(p_q[P1-1].e) + 34'h80_0000;
    p_d[P1].yg  = yg_sum[32:24];
  end

  // post stage 2: squareplus correction and saturation
  logic signed [37:0] dd2;
  logic               bump;
  logic signed [17:0] n1;
  always_comb begin
    p_d[P2] = p_q[P1];
    dd2  = 38'(p_q[P1].spd) * 38'(p_q[P1].spd);
    bump = (p_q[P1].spd <= 19'sd0) || (dd2 <= $signed({7'd0, p_q[P1].s}));
    n1   = bump ? p_q[P1].spn + 18'sd1 : p_q[P1].spn;
    if (n1 > 18'sd32767) begin
      p_d[P2].sat = 1'b1;
      p_d[P2].ysp = 16'h7fff;
    end else begin
      p_d[P2].sat = 1'b0;
      p_d[P2].ysp = n1[15:0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    afu_div_step #(.Sh(DIV_STEPS - 1 - k)) u_div (.p_i(p_q[P2+k]), .p_o(p_d[P2+k+1]));
  end

  // output select
  pipe_t pf;
  logic [17:0] rnd;
  logic [15:0] mag;
  always_comb begin
    pf    = p_q[NST-1];
    rnd   = (18'(pf.q) + 18'd1) >> 1;
    mag   = rnd[15:0];
    sat_d = 1'b0;
    case (pf.mode) inside
      MODE_STEP:  y_d = pf.a[15] ? 16'sd0 : 16'sd256;
      MODE_RELU:  y_d = pf.a[15] ? 16'sd0 : pf.a;
      MODE_SQP: begin
        y_d   = $signed(pf.ysp);
        sat_d = pf.sat;
      end
      MODE_GAUSS: y_d = $signed({7'd0, pf.yg});
      MODE_TANH, MODE_SWISH: y_d = pf.a[15] ? -$signed(mag) : $signed(mag);
      default:    y_d = 16'sd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vo_q  <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
      vo_q  <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        p_q[i] <= p_d[i];
      end
      y_q   <= y_d;
      sat_q <= sat_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/afu_checker.sv =====
// Port-level checks for the activation function unit, bound to the top level.
// Depends on activation_function_unit ports only.
`default_nettype none

module afu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        stall_o,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [15:0] y_o,
  input wire logic        saturated_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(y_o) && $stable(saturated_o))
    else $error("stalled result changed");

  a_sat_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && saturated_o |-> y_o == 16'h7fff)
    else $error("saturated result not at max");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("request stalled without blocked result");

endmodule

bind activation_function_unit afu_checker u_afu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .stall_o(stall_o), .valid_o(valid_o),
  .stall_i(stall_i), .y_o(y_o), .saturated_o(saturated_o)
);

`default_nettype wire

// ===== tb/sv/activation_function_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for activation_function_unit: directed and random requests and result stalls,
// each result checked against a Q60 integer model of the six functions.
// Depends on afu_pkg and the activation_function_unit RTL.

module activation_function_unit_tb;
  import afu_pkg::*;

  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [2:0]         mode;
    logic signed [15:0] x;
  } request_t;

  typedef struct {
    logic signed [15:0] y;
    logic               sat;
  } act_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic [2:0] mode_i = MODE_STEP;
  logic signed [15:0] x_i = '0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, saturated_o;
  logic signed [15:0] y_o;

  request_t    pending_reqs[$];
  act_result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;

  activation_function_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .mode_i(mode_i), .x_i(x_i), .valid_o(valid_o), .stall_i(stall_i),
    .y_o(y_o), .saturated_o(saturated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] frac_div(logic [63:0] n, logic [63:0] d, int k);
    logic [63:0] q, r;
    q = 0;
    r = n;
    for (int i = 0; i < k; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-n / 2^f) in Q60: series on (n / 2^f) / 256, then 8 squarings
  function automatic logic [63:0] exp_neg_q60(logic [63:0] n, int f);
    logic [63:0] t, term, sum;
    if (n >= (64'd44 << f)) return 64'd0;
    t = n << (52 - f);
    term = ONE_Q60;
    sum = ONE_Q60;
    for (int k = 1; k <= 12; k++) begin
      term = mul_q60(term, t) / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    for (int k = 0; k < 8; k++) sum = mul_q60(sum, sum);
    return sum;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic act_result_t activation(request_t req);
    act_result_t res;
    longint a, y, s, t, n, d;
    logic [63:0] m, e, q, den;
    a = longint'(req.x);
    m = (a < 0) ? 64'(-a) : 64'(a);
    y = 0;
    res.sat = 1'b0;
    case (req.mode)
      MODE_STEP: y = (a >= 0) ? 256 : 0;
      MODE_RELU: y = (a >= 0) ? a : 0;
      MODE_SQP: begin
        s = a * a + 131072;
        t = longint'(int_sqrt(64'(s)));
        n = (a + 1 + t) / 2;
        d = 2 * (n + 1) - a - 1;
        if (d <= 0 || d * d <= s) n = n + 1;
        if (n > 32767) begin
          res.sat = 1'b1;
          n = 32767;
        end
        y = n;
      end
      MODE_GAUSS: begin
        e = exp_neg_q60(64'(a * a), 16);
        y = longint'((e + (64'd1 << 51)) >> 52);
      end
      MODE_TANH: begin
        e = exp_neg_q60(m, 7);
        q = frac_div(ONE_Q60 - e, ONE_Q60 + e, 9);
        y = longint'((q + 1) >> 1);
        if (a < 0) y = -y;
      end
      MODE_SWISH: begin
        e = exp_neg_q60(m, 9);
        den = ONE_Q60 + e;
        if (a >= 0) begin
          q = frac_div(2 * m, den, 60);
          y = longint'((q + 1) >> 1);
        end else begin
          q = mul_q60(2 * m, frac_div(e, den, 60));
          y = -longint'((q + 1) >> 1);
        end
      end
      default: y = 0;
    endcase
    res.y = y[15:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic nv;
    int g;
    request_t req;
    if (!rst_ni) begin
      valid_i <= 1'b0;
      mode_i <= MODE_STEP;
      x_i <= '0;
      send_gap <= 0;
    end else begin
      nv = valid_i;
      g = send_gap;
      if (valid_i && !stall_o) begin
        req.mode = mode_i;
        req.x = x_i;
        expected_results.push_back(activation(req));
        nv = 1'b0;
        g = pick_gap();
      end
      if (!nv) begin
        if (g != 0) begin
          g = g - 1;
        end else if (pending_reqs.size() != 0) begin
          req = pending_reqs.pop_front();
          nv = 1'b1;
          mode_i <= req.mode;
          x_i <= req.x;
        end
      end
      valid_i <= nv;
      send_gap <= g;
    end
  end

  // result monitor and stall generator
  always @(posedge clk_i or negedge rst_ni) begin
    act_result_t exp_res;
    if (!rst_ni) begin
      stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result y=%0d sat=%0b", y_o, saturated_o);
        end else begin
          exp_res = expected_results.pop_front();
          if (y_o !== exp_res.y || saturated_o !== exp_res.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected y=%0d sat=%0b, got y=%0d sat=%0b",
                       exp_res.y, exp_res.sat, y_o, saturated_o);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        stall_i <= 1'b1;
      end else begin
        stall_left <= pick_gap();
        stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_request(logic [2:0] mode, logic signed [15:0] x);
    request_t req;
    req.mode = mode;
    req.x = x;
    pending_reqs.push_back(req);
  endtask

  initial begin
    logic [2:0] mode;
    logic signed [15:0] x;
    int r;
    for (int md = 0; md < 6; md++) begin
      add_request(3'(md), 16'sh7FFF);
      add_request(3'(md), 16'sh8000);
    end
    add_request(MODE_STEP, 16'sd0);
    add_request(MODE_STEP, -16'sd1);
    add_request(MODE_RELU, 16'sd1);
    add_request(MODE_SQP, 16'sh7FFE);
    add_request(MODE_SQP, 16'sd0);
    add_request(MODE_GAUSS, 16'sd0);
    add_request(MODE_TANH, 16'sd1);
    add_request(MODE_TANH, -16'sd1);
    add_request(MODE_SWISH, 16'sd1);
    add_request(MODE_SWISH, -16'sd1);
    add_request(3'd6, 16'sh5A5A);
    add_request(3'd7, 16'shA5A5);
    for (int i = 0; i < 800; i++) begin
      r = $urandom_range(0, 19);
      mode = (r == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      r = $urandom_range(0, 3);
      if (r == 0) x = 16'($urandom_range(0, 65535));
      else x = 16'(int'($urandom_range(0, 2047)) - 1024);
      add_request(mode, x);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pending_reqs.size() == 0 && !valid_i && expected_results.size() == 0) break;
    end
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/afu_pkg.sv
hw/rtl/afu_exp_step.sv
hw/rtl/afu_div_step.sv
hw/rtl/activation_function_unit.sv
hw/rtl/afu_checker.sv
tb/sv/activation_function_unit_tb.sv
